// File: hw/rtl/keyword_lexer_tokenizer_assert.svh
// assertion macros for the lexer checker
`ifndef KEYWORD_LEXER_TOKENIZER_ASSERT_SVH
`define KEYWORD_LEXER_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define KWLT_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KWLT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/kwlt_pkg.sv
package kwlt_pkg;

   localparam int KEYWORD_MAX_LEN = 8;
   localparam int POSITION_BITS   = 24;
   localparam int FIELD_BITS      = 24;
   localparam int LINE_BITS       = 24;
   localparam int KW_BITS         = 8 * KEYWORD_MAX_LEN;
   localparam int LEN_BITS        = $clog2(KEYWORD_MAX_LEN + 1);
   localparam int NUM_KEYS        = 27;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] KIND_LPAREN  = 6'd0;
   localparam logic [5:0] KIND_RPAREN  = 6'd1;
   localparam logic [5:0] KIND_COMMA   = 6'd2;
   localparam logic [5:0] KIND_DOT     = 6'd3;
   localparam logic [5:0] KIND_STRING  = 6'd4;
   localparam logic [5:0] KIND_NUMBER  = 6'd5;
   localparam logic [5:0] KIND_IDENT   = 6'd6;
   localparam int         KIND_KEY0    = 7;
   localparam logic [5:0] KIND_EOF     = 6'd34;
   localparam logic [5:0] KIND_BADCHAR = 6'd35;
   localparam logic [5:0] KIND_UNTERM  = 6'd36;

   // keyword text right-aligned, first byte most significant
   localparam logic [KW_BITS-1:0] KEY_TEXT [NUM_KEYS] = '{
      KW_BITS'("plus"), KW_BITS'("minus"), KW_BITS'("into"), KW_BITS'("div"),
      KW_BITS'("reminder"), KW_BITS'("greater"), KW_BITS'("lesser"),
      KW_BITS'("equal"), KW_BITS'("not"), KW_BITS'("and"), KW_BITS'("or"),
      KW_BITS'("when"), KW_BITS'("then"), KW_BITS'("nothing"), KW_BITS'("with"),
      KW_BITS'("from"), KW_BITS'("to"), KW_BITS'("how"), KW_BITS'("so"),
      KW_BITS'("thats"), KW_BITS'("please"), KW_BITS'("give"), KW_BITS'("var"),
      KW_BITS'("is"), KW_BITS'("read"), KW_BITS'("as"), KW_BITS'("say")
   };
   localparam logic [LEN_BITS-1:0] KEY_LEN [NUM_KEYS] = '{
      LEN_BITS'(4), LEN_BITS'(5), LEN_BITS'(4), LEN_BITS'(3), LEN_BITS'(8),
      LEN_BITS'(7), LEN_BITS'(6), LEN_BITS'(5), LEN_BITS'(3), LEN_BITS'(3),
      LEN_BITS'(2), LEN_BITS'(4), LEN_BITS'(4), LEN_BITS'(7), LEN_BITS'(4),
      LEN_BITS'(4), LEN_BITS'(2), LEN_BITS'(3), LEN_BITS'(2), LEN_BITS'(5),
      LEN_BITS'(6), LEN_BITS'(4), LEN_BITS'(3), LEN_BITS'(2), LEN_BITS'(4),
      LEN_BITS'(2), LEN_BITS'(3)
   };
   localparam logic [KW_BITS-1:0]  COMMENT_TEXT = KW_BITS'("comment");
   localparam logic [LEN_BITS-1:0] COMMENT_LEN  = LEN_BITS'(7);

   typedef enum logic [3:0] {
      CLS_LPAREN, CLS_RPAREN, CLS_COMMA, CLS_DOT, CLS_QUOTE,
      CLS_SPACE, CLS_NEWLINE, CLS_DIGIT, CLS_ALPHA, CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic [5:0]            kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic [LINE_BITS-1:0]  line;
      logic [7:0]            bad;
   } token_type;

   // results of one source byte: one or two tokens
   typedef struct packed {
      token_type tok0;
      token_type tok1;
      logic      two;
   } entry_type;

   function automatic char_class_type char_class(input logic [7:0] c);
      char_class_type cls;
      case (c) inside
         8'h28:                         cls = CLS_LPAREN;
         8'h29:                         cls = CLS_RPAREN;
         8'h2c:                         cls = CLS_COMMA;
         8'h2e:                         cls = CLS_DOT;
         8'h22:                         cls = CLS_QUOTE;
         8'h20, 8'h0d, 8'h09:           cls = CLS_SPACE;
         8'h0a:                         cls = CLS_NEWLINE;
         [8'h30:8'h39]:                 cls = CLS_DIGIT;
         [8'h41:8'h5a], [8'h61:8'h7a], 8'h5f: cls = CLS_ALPHA;
         default:                       cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

   function automatic logic word_matches(input logic [KW_BITS-1:0] word,
                                         input logic [POSITION_BITS-1:0] len,
                                         input logic [KW_BITS-1:0] text,
                                         input logic [LEN_BITS-1:0] tlen);
      return (len == POSITION_BITS'(tlen)) && (word == text);
   endfunction

   // parallel compare against every keyword
   function automatic logic [5:0] keyword_kind(input logic [KW_BITS-1:0] word,
                                               input logic [POSITION_BITS-1:0] len);
      logic [5:0] kind;
      kind = KIND_IDENT;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (word_matches(word, len, KEY_TEXT[i], KEY_LEN[i])) begin
            kind = 6'(KIND_KEY0 + i);
         end
      end
      return kind;
   endfunction

endpackage

// File: hw/rtl/kwlt_channels.sv
interface kwlt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;
   modport source(output valid, ch, end_of_input, input ready);
   modport sink(input valid, ch, end_of_input, output ready);
endinterface

interface kwlt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [5:0]                      token_kind;
   logic [kwlt_pkg::FIELD_BITS-1:0] token_start;
   logic [kwlt_pkg::FIELD_BITS-1:0] token_length;
   logic [kwlt_pkg::LINE_BITS-1:0]  token_line;
   logic [7:0]                      bad_char;
   logic                            last;
   modport source(output valid, token_kind, token_start, token_length, token_line,
                  bad_char, last, input ready);
   modport sink(input valid, token_kind, token_start, token_length, token_line,
                bad_char, last, output ready);
endinterface

interface kwlt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [kwlt_pkg::LINE_BITS-1:0] first_line;
   modport source(output valid, first_line, input ready);
   modport sink(input valid, first_line, output ready);
endinterface

// File: hw/rtl/keyword_lexer_tokenizer.sv
// Streaming keyword lexer. Source bytes enter on req_if one beat per cycle, with
// end_of_input marking the end of the text; each byte is scanned in the cycle it
// is accepted and its tokens (none, one or two) go into a four-entry queue. The
// output stage sends one token beat per cycle on rsp_if while ready is high, so
// a byte that closes a pending number or word and is itself a token gives two
// beats; the queue absorbs such bursts and req_if.ready drops only when full.
// Each token is registered in the queue, then in the output register. The
// first_line register is written on csr_if, which is always ready; it also
// reloads the line count when no byte has been taken since the last clear.
module keyword_lexer_tokenizer (
   input  logic        clock,
   input  logic        reset,
   kwlt_req_if.sink    req_if,
   kwlt_rsp_if.source  rsp_if,
   kwlt_csr_if.sink    csr_if
);

   logic                queue_full;
   logic                queue_empty;
   logic                push;
   logic                pop;
   kwlt_pkg::entry_type push_entry;
   kwlt_pkg::entry_type head;

   kwlt_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   kwlt_token_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   kwlt_emitter u_emitter (
      .clock  (clock),
      .reset  (reset),
      .empty  (queue_empty),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

// File: hw/rtl/kwlt_scanner.sv
module kwlt_scanner (
   input  logic                clock,
   input  logic                reset,
   kwlt_req_if.sink            req_if,
   kwlt_csr_if.sink            csr_if,
   input  logic                queue_full,
   output logic                push,
   output kwlt_pkg::entry_type push_entry
);

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_NUMBER, MODE_IDENT, MODE_STRING, MODE_COMMENT
   } mode_type;

   localparam int PB = kwlt_pkg::POSITION_BITS;
   localparam int FB = kwlt_pkg::FIELD_BITS;
   localparam int LB = kwlt_pkg::LINE_BITS;
   localparam int KB = kwlt_pkg::KW_BITS;

   mode_type       mode_ff, mode_in;
   logic [PB-1:0]  pos_ff, pos_in;
   logic [PB-1:0]  start_ff, start_in;
   logic [LB-1:0]  line_ff, line_in;
   logic [KB-1:0]  word_ff, word_in;
   logic [LB-1:0]  first_line_ff, first_line_in;

   logic                     fire;
   logic                     cfg_fire;
   logic [PB-1:0]            len;
   kwlt_pkg::char_class_type cls;
   logic                     is_comment;

   // idle-mode scan of the current byte
   logic                idle_emit;
   kwlt_pkg::token_type idle_tok;
   mode_type            idle_mode;
   logic                idle_setstart;
   logic                idle_newword;
   logic                idle_bump;

   logic                use_idle;
   logic                bump;
   logic                pend_v;
   kwlt_pkg::token_type pend_tok;
   kwlt_pkg::token_type second_tok;
   logic                second_v;

   assign fire     = req_if.valid && req_if.ready;
   assign cfg_fire = csr_if.valid && csr_if.ready;
   assign req_if.ready = !queue_full;
   assign csr_if.ready = 1'b1;

   assign len        = pos_ff - start_ff;
   assign cls        = kwlt_pkg::char_class(req_if.ch);
   assign is_comment = kwlt_pkg::word_matches(word_ff, len, kwlt_pkg::COMMENT_TEXT,
                                              kwlt_pkg::COMMENT_LEN);

   always_comb begin
      idle_emit       = 1'b0;
      idle_mode       = MODE_IDLE;
      idle_setstart   = 1'b0;
      idle_newword    = 1'b0;
      idle_bump       = 1'b0;
      idle_tok.kind   = kwlt_pkg::KIND_BADCHAR;
      idle_tok.start  = FB'(pos_ff);
      idle_tok.length = FB'(1);
      idle_tok.line   = line_ff;
      idle_tok.bad    = 8'd0;
      case (cls)
         kwlt_pkg::CLS_LPAREN: begin
            idle_emit     = 1'b1;
            idle_tok.kind = kwlt_pkg::KIND_LPAREN;
         end
         kwlt_pkg::CLS_RPAREN: begin
            idle_emit     = 1'b1;
            idle_tok.kind = kwlt_pkg::KIND_RPAREN;
         end
         kwlt_pkg::CLS_COMMA: begin
            idle_emit     = 1'b1;
            idle_tok.kind = kwlt_pkg::KIND_COMMA;
         end
         kwlt_pkg::CLS_DOT: begin
            idle_emit     = 1'b1;
            idle_tok.kind = kwlt_pkg::KIND_DOT;
         end
         kwlt_pkg::CLS_QUOTE: begin
            idle_mode     = MODE_STRING;
            idle_setstart = 1'b1;
         end
         kwlt_pkg::CLS_SPACE: begin
         end
         kwlt_pkg::CLS_NEWLINE: begin
            idle_bump = 1'b1;
         end
         kwlt_pkg::CLS_DIGIT: begin
            idle_mode     = MODE_NUMBER;
            idle_setstart = 1'b1;
         end
         kwlt_pkg::CLS_ALPHA: begin
            idle_mode     = MODE_IDENT;
            idle_setstart = 1'b1;
            idle_newword  = 1'b1;
         end
         default: begin
            idle_emit       = 1'b1;
            idle_tok.length = '0;
            idle_tok.bad    = req_if.ch;
         end
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      start_in      = start_ff;
      line_in       = line_ff;
      word_in       = word_ff;
      first_line_in = first_line_ff;
      use_idle      = 1'b0;
      bump          = 1'b0;
      pend_v        = 1'b0;

      pend_tok.kind   = kwlt_pkg::KIND_NUMBER;
      pend_tok.start  = FB'(start_ff);
      pend_tok.length = FB'(len);
      pend_tok.line   = line_ff;
      pend_tok.bad    = 8'd0;

      if (req_if.end_of_input) begin
         case (mode_ff)
            MODE_NUMBER: pend_v = 1'b1;
            MODE_IDENT: begin
               pend_v        = !is_comment;
               pend_tok.kind = kwlt_pkg::keyword_kind(word_ff, len);
            end
            MODE_STRING: begin
               pend_v          = 1'b1;
               pend_tok.kind   = kwlt_pkg::KIND_UNTERM;
               pend_tok.length = '0;
            end
            default: pend_v = 1'b0;
         endcase
      end else begin
         case (mode_ff)
            MODE_NUMBER: begin
               if (cls != kwlt_pkg::CLS_DIGIT) begin
                  pend_v   = 1'b1;
                  use_idle = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (cls == kwlt_pkg::CLS_ALPHA || cls == kwlt_pkg::CLS_DIGIT) begin
                  // once the offset is pinned the length stops and the word stays put
                  if (len < PB'(kwlt_pkg::KEYWORD_MAX_LEN) && pos_ff != '1) begin
                     word_in = {word_ff[KB-9:0], req_if.ch};
                  end
               end else if (is_comment) begin
                  // comment word: rest of the line is dropped
                  if (cls == kwlt_pkg::CLS_NEWLINE) begin
                     mode_in = MODE_IDLE;
                     bump    = 1'b1;
                  end else begin
                     mode_in = MODE_COMMENT;
                  end
               end else begin
                  pend_v        = 1'b1;
                  pend_tok.kind = kwlt_pkg::keyword_kind(word_ff, len);
                  use_idle      = 1'b1;
               end
            end
            MODE_STRING: begin
               if (cls == kwlt_pkg::CLS_QUOTE) begin
                  pend_v          = 1'b1;
                  pend_tok.kind   = kwlt_pkg::KIND_STRING;
                  pend_tok.start  = FB'({1'b0, start_ff} + 1'b1);
                  pend_tok.length = (len == '0) ? '0 : FB'(len - 1'b1);
                  mode_in         = MODE_IDLE;
               end else if (cls == kwlt_pkg::CLS_NEWLINE) begin
                  bump = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (cls == kwlt_pkg::CLS_NEWLINE) begin
                  bump    = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
            default: use_idle = 1'b1;
         endcase

         if (use_idle) begin
            mode_in = idle_mode;
            bump    = bump | idle_bump;
            if (idle_setstart) begin
               start_in = pos_ff;
            end
            if (idle_newword) begin
               word_in = KB'(req_if.ch);
            end
         end
         if (bump && line_ff != '1) begin
            line_in = line_ff + 1'b1;
         end
         if (pos_ff != '1) begin
            pos_in = pos_ff + 1'b1;
         end
      end

      second_tok = idle_tok;
      second_v   = use_idle && idle_emit;
      if (req_if.end_of_input) begin
         second_tok.kind   = kwlt_pkg::KIND_EOF;
         second_tok.start  = FB'(pos_ff);
         second_tok.length = '0;
         second_tok.bad    = 8'd0;
         second_v          = 1'b1;
      end

      if (pend_v) begin
         push_entry.tok0 = pend_tok;
         push_entry.tok1 = second_tok;
         push_entry.two  = second_v;
      end else begin
         push_entry.tok0 = second_tok;
         push_entry.tok1 = second_tok;
         push_entry.two  = 1'b0;
      end
      push = fire && (pend_v || second_v);

      if (!fire) begin
         mode_in  = mode_ff;
         pos_in   = pos_ff;
         start_in = start_ff;
         line_in  = line_ff;
         word_in  = word_ff;
      end else if (req_if.end_of_input) begin
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         line_in  = first_line_ff;
         word_in  = '0;
      end

      if (cfg_fire) begin
         first_line_in = csr_if.first_line;
         if (pos_ff == '0) begin
            line_in = csr_if.first_line;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         pos_ff        <= '0;
         start_ff      <= '0;
         line_ff       <= LB'(1);
         word_ff       <= '0;
         first_line_ff <= LB'(1);
      end else begin
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         start_ff      <= start_in;
         line_ff       <= line_in;
         word_ff       <= word_in;
         first_line_ff <= first_line_in;
      end
   end

endmodule

// File: hw/rtl/kwlt_token_queue.sv
module kwlt_token_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kwlt_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output kwlt_pkg::entry_type head
);

   localparam int PW = kwlt_pkg::QUEUE_PTR_BITS;
   localparam int CW = kwlt_pkg::QUEUE_CNT_BITS;

   kwlt_pkg::entry_type slot_ff [kwlt_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(kwlt_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/kwlt_emitter.sv
module kwlt_emitter (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  kwlt_pkg::entry_type head,
   output logic                pop,
   kwlt_rsp_if.source          rsp_if
);

   logic                out_v_ff, out_v_in;
   logic                out_last_ff, out_last_in;
   kwlt_pkg::token_type out_tok_ff, out_tok_in;
   logic                pend_v_ff, pend_v_in;
   kwlt_pkg::token_type pend_tok_ff, pend_tok_in;
   logic                load;

   // output register is free or its beat goes this cycle
   assign load = !out_v_ff || rsp_if.ready;
   assign pop  = load && !pend_v_ff && !empty;

   always_comb begin
      out_v_in    = out_v_ff;
      out_last_in = out_last_ff;
      out_tok_in  = out_tok_ff;
      pend_v_in   = pend_v_ff;
      pend_tok_in = pend_tok_ff;
      if (load) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_tok_in  = pend_tok_ff;
            out_last_in = 1'b1;
            pend_v_in   = 1'b0;
         end else if (!empty) begin
            out_v_in    = 1'b1;
            out_tok_in  = head.tok0;
            out_last_in = !head.two;
            pend_v_in   = head.two;
            pend_tok_in = head.tok1;
         end else begin
            out_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_last_ff <= out_last_in;
      out_tok_ff  <= out_tok_in;
      pend_tok_ff <= pend_tok_in;
   end

   assign rsp_if.valid        = out_v_ff;
   assign rsp_if.token_kind   = out_tok_ff.kind;
   assign rsp_if.token_start  = out_tok_ff.start;
   assign rsp_if.token_length = out_tok_ff.length;
   assign rsp_if.token_line   = out_tok_ff.line;
   assign rsp_if.bad_char     = out_tok_ff.bad;
   assign rsp_if.last         = out_last_ff;

endmodule

// File: hw/rtl/kwlt_checker.sv
`include "keyword_lexer_tokenizer_assert.svh"

module kwlt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [5:0]                      token_kind,
   input logic [kwlt_pkg::FIELD_BITS-1:0] token_start,
   input logic [kwlt_pkg::FIELD_BITS-1:0] token_length,
   input logic [kwlt_pkg::LINE_BITS-1:0]  token_line,
   input logic [7:0]                      bad_char,
   input logic                            last
);

   localparam int BEAT_BITS = 6 + 2 * kwlt_pkg::FIELD_BITS + kwlt_pkg::LINE_BITS + 8 + 1;

   logic                 stalled;
   logic [BEAT_BITS-1:0] beat_bits;
   logic                 is_eof;
   logic                 is_error;
   logic                 not_badchar;
   logic                 is_unterm;

   assign stalled     = rsp_valid && !rsp_ready;
   assign beat_bits   = {token_kind, token_start, token_length, token_line, bad_char, last};
   assign is_eof      = rsp_valid && token_kind == kwlt_pkg::KIND_EOF;
   assign is_unterm   = rsp_valid && token_kind == kwlt_pkg::KIND_UNTERM;
   assign is_error    = is_unterm || (rsp_valid && token_kind == kwlt_pkg::KIND_BADCHAR);
   assign not_badchar = rsp_valid && token_kind != kwlt_pkg::KIND_BADCHAR;

   // a stalled beat keeps its token
   `KWLT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(beat_bits), "stalled token changed")

   // end of file closes its item and has no text
   `KWLT_HOLDS(a_eof_last, is_eof, last && token_length == '0, "eof not last or not empty")

   // error tokens carry no length
   `KWLT_HOLDS(a_err_len, is_error, token_length == '0, "error token with length")

   // offending byte only on its own error kind
   `KWLT_HOLDS(a_bad_zero, not_badchar, bad_char == 8'd0, "stray offending byte")

   // an unterminated string is always followed by end of file
   `KWLT_HOLDS(a_unterm_not_last, is_unterm, !last, "unterminated string marked last")

endmodule

bind keyword_lexer_tokenizer kwlt_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .token_kind   (rsp_if.token_kind),
   .token_start  (rsp_if.token_start),
   .token_length (rsp_if.token_length),
   .token_line   (rsp_if.token_line),
   .bad_char     (rsp_if.bad_char),
   .last         (rsp_if.last)
);

// File: verif/keyword_lexer_tokenizer_test.sv
`timescale 1ns / 1ps

module keyword_lexer_tokenizer_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PRINT_LIMIT    = 40;
   localparam int KMAX           = kwlt_pkg::KEYWORD_MAX_LEN;
   localparam int KWB            = kwlt_pkg::KW_BITS;

   localparam logic [7:0] B_LPAREN = 8'h28;
   localparam logic [7:0] B_RPAREN = 8'h29;
   localparam logic [7:0] B_COMMA  = 8'h2c;
   localparam logic [7:0] B_DOT    = 8'h2e;
   localparam logic [7:0] B_QUOTE  = 8'h22;
   localparam logic [7:0] B_SPACE  = 8'h20;
   localparam logic [7:0] B_CR     = 8'h0d;
   localparam logic [7:0] B_TAB    = 8'h09;
   localparam logic [7:0] B_NL     = 8'h0a;

   localparam logic [23:0] FIELD_MAX = 24'hFFFFFF;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_STRING, SCAN_COMMENT
   } scan_mode_type;

   typedef enum logic [1:0] {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } src_beat_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [23:0] start;
      logic [23:0] length;
      logic [23:0] line;
      logic [7:0]  bad;
      logic        last;
   } lex_token_type;

   logic clock;
   logic reset;

   kwlt_req_if req_bus();
   kwlt_rsp_if rsp_bus();
   kwlt_csr_if csr_bus();

   keyword_lexer_tokenizer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // scanner copy kept alongside the block
   scan_mode_type mode_q;
   logic [23:0]   pos_q;
   logic [23:0]   start_q;
   logic [23:0]   line_q;
   logic [23:0]   first_line_q;
   logic [7:0]    word_q [KMAX];

   src_beat_type  pending_beats [$];
   lex_token_type expected_tokens [$];

   idle_mode_type idle_mode = IDLE_NONE;
   logic       rsp_hold = 1'b0;
   logic       hold_wanted = 1'b0;
   int         beats_offered = 0;
   int         beats_taken = 0;
   int         idle_cycles = 0;
   logic       progress;
   int         fail_count = 0;
   int         tokens_checked = 0;
   int         bytes_queued = 0;
   int         ends_queued = 0;
   int         csr_writes = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic byte_is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic byte_is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic byte_is_lexical(input logic [7:0] c);
      return byte_is_digit(c) || byte_is_letter(c) || c == B_LPAREN || c == B_RPAREN
         || c == B_COMMA || c == B_DOT || c == B_QUOTE || c == B_SPACE || c == B_CR
         || c == B_TAB || c == B_NL;
   endfunction

   function automatic void clear_scan();
      mode_q  = SCAN_IDLE;
      pos_q   = '0;
      start_q = '0;
      line_q  = first_line_q;
      for (int i = 0; i < KMAX; i++) word_q[i] = 8'h00;
   endfunction

   function automatic void bump_line();
      if (line_q != FIELD_MAX) line_q = line_q + 24'd1;
   endfunction

   function automatic void push_token(input logic [5:0] kind, input logic [23:0] start,
                                      input logic [23:0] len, input logic [7:0] bad);
      lex_token_type tok;
      tok = '{kind, start, len, line_q, bad, 1'b0};
      expected_tokens.insert(expected_tokens.size(), tok);
   endfunction

   // first len bytes of the word, right-aligned with the first byte on top
   function automatic logic [KWB-1:0] word_text(input logic [23:0] len);
      logic [KWB-1:0] w;
      w = '0;
      for (int i = 0; i < KMAX; i++) begin
         if (i < len) w = {w[KWB-9:0], word_q[i]};
      end
      return w;
   endfunction

   function automatic logic is_comment_word(input logic [23:0] len);
      return len == 24'(kwlt_pkg::COMMENT_LEN) && word_text(len) == kwlt_pkg::COMMENT_TEXT;
   endfunction

   function automatic logic [5:0] word_kind_of(input logic [23:0] len);
      logic [5:0]     k;
      logic [KWB-1:0] w;
      k = kwlt_pkg::KIND_IDENT;
      w = word_text(len);
      if (len <= KMAX) begin
         for (int j = 0; j < kwlt_pkg::NUM_KEYS; j++) begin
            if (len == 24'(kwlt_pkg::KEY_LEN[j]) && w == kwlt_pkg::KEY_TEXT[j])
               k = 6'(kwlt_pkg::KIND_KEY0 + j);
         end
      end
      return k;
   endfunction

   // a byte seen with nothing pending
   function automatic void scan_fresh(input logic [7:0] c);
      case (c)
         B_LPAREN: push_token(kwlt_pkg::KIND_LPAREN, pos_q, 24'd1, 8'h00);
         B_RPAREN: push_token(kwlt_pkg::KIND_RPAREN, pos_q, 24'd1, 8'h00);
         B_COMMA:  push_token(kwlt_pkg::KIND_COMMA, pos_q, 24'd1, 8'h00);
         B_DOT:    push_token(kwlt_pkg::KIND_DOT, pos_q, 24'd1, 8'h00);
         B_QUOTE: begin
            mode_q  = SCAN_STRING;
            start_q = pos_q;
         end
         B_SPACE, B_CR, B_TAB: ;
         B_NL: bump_line();
         default: begin
            if (byte_is_digit(c)) begin
               mode_q  = SCAN_NUMBER;
               start_q = pos_q;
            end else if (byte_is_letter(c)) begin
               mode_q  = SCAN_WORD;
               start_q = pos_q;
               for (int i = 0; i < KMAX; i++) word_q[i] = 8'h00;
               word_q[0] = c;
            end else begin
               push_token(kwlt_pkg::KIND_BADCHAR, pos_q, 24'd0, c);
            end
         end
      endcase
   endfunction

   function automatic void lex_byte(input logic [7:0] c, input logic eoi);
      logic [23:0] len;
      int          queued;
      len    = pos_q - start_q;
      queued = expected_tokens.size();
      if (eoi) begin
         case (mode_q)
            SCAN_NUMBER: push_token(kwlt_pkg::KIND_NUMBER, start_q, len, 8'h00);
            SCAN_WORD: begin
               if (!is_comment_word(len)) push_token(word_kind_of(len), start_q, len, 8'h00);
            end
            SCAN_STRING: push_token(kwlt_pkg::KIND_UNTERM, start_q, 24'd0, 8'h00);
            default: ;
         endcase
         push_token(kwlt_pkg::KIND_EOF, pos_q, 24'd0, 8'h00);
         clear_scan();
      end else begin
         case (mode_q)
            SCAN_NUMBER: begin
               if (!byte_is_digit(c)) begin
                  push_token(kwlt_pkg::KIND_NUMBER, start_q, len, 8'h00);
                  mode_q = SCAN_IDLE;
                  scan_fresh(c);
               end
            end
            SCAN_WORD: begin
               if (byte_is_letter(c) || byte_is_digit(c)) begin
                  if (len < KMAX) word_q[len[2:0]] = c;
               end else if (is_comment_word(len)) begin
                  // the closing byte goes with the rest of the line
                  if (c == B_NL) begin
                     mode_q = SCAN_IDLE;
                     bump_line();
                  end else begin
                     mode_q = SCAN_COMMENT;
                  end
               end else begin
                  push_token(word_kind_of(len), start_q, len, 8'h00);
                  mode_q = SCAN_IDLE;
                  scan_fresh(c);
               end
            end
            SCAN_STRING: begin
               if (c == B_QUOTE) begin
                  push_token(kwlt_pkg::KIND_STRING, start_q + 24'd1,
                             (len > 0) ? len - 24'd1 : 24'd0, 8'h00);
                  mode_q = SCAN_IDLE;
               end else if (c == B_NL) begin
                  bump_line();
               end
            end
            SCAN_COMMENT: begin
               if (c == B_NL) begin
                  bump_line();
                  mode_q = SCAN_IDLE;
               end
            end
            default: begin
               mode_q = SCAN_IDLE;
               scan_fresh(c);
            end
         endcase
         if (pos_q != FIELD_MAX) pos_q = pos_q + 24'd1;
      end
      if (expected_tokens.size() > queued) begin
         expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic void check_field(input string what, input logic [23:0] want,
                                       input logic [23:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   function automatic logic sender_gap();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 78;
         IDLE_BOTH:   return $urandom_range(0, 99) < 38;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stall();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 78;
         IDLE_BOTH:     return $urandom_range(0, 99) < 38;
         default:       return 1'b0;
      endcase
   endfunction

   // source side: next byte once the current beat has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && beats_offered != beats_taken)) begin
         if (pending_beats.size() != 0 && !sender_gap()) begin
            req_bus.ch           <= pending_beats[0].ch;
            req_bus.end_of_input <= pending_beats[0].eoi;
            req_bus.valid        <= 1'b1;
            void'(pending_beats.pop_front());
            beats_offered++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && !rsp_hold && !receiver_stall();
   end

   initial begin : rx_hold_off
      while (!hold_wanted) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            lex_byte(req_bus.ch, req_bus.end_of_input);
            beats_taken++;
            progress = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            progress = 1'b1;
            if (expected_tokens.size() == 0) begin
               fail_count++;
               if (fail_count <= PRINT_LIMIT)
                  $display("%0t: token beat with none expected, expected nothing, got kind %0d",
                           $time, rsp_bus.token_kind);
            end else begin
               check_field("token_kind", 24'(expected_tokens[0].kind), 24'(rsp_bus.token_kind));
               check_field("token_start", expected_tokens[0].start, rsp_bus.token_start);
               check_field("token_length", expected_tokens[0].length, rsp_bus.token_length);
               check_field("token_line", expected_tokens[0].line, rsp_bus.token_line);
               check_field("bad_char", 24'(expected_tokens[0].bad), 24'(rsp_bus.bad_char));
               check_field("last", 24'(expected_tokens[0].last), 24'(rsp_bus.last));
               void'(expected_tokens.pop_front());
               tokens_checked++;
            end
         end
         if (csr_bus.valid && csr_bus.ready) progress = 1'b1;
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d tokens outstanding", $time,
                     idle_cycles, expected_tokens.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic void push_byte(input logic [7:0] c);
      src_beat_type beat;
      beat = '{c, 1'b0};
      pending_beats.insert(pending_beats.size(), beat);
      bytes_queued++;
   endfunction

   function automatic void push_end();
      src_beat_type beat;
      beat = '{8'($urandom_range(0, 255)), 1'b1};
      pending_beats.insert(pending_beats.size(), beat);
      bytes_queued++;
      ends_queued++;
   endfunction

   function automatic void push_str(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic logic [7:0] random_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'(8'h61 + r);
      if (r < 52) return 8'(8'h41 + r - 26);
      return 8'h5f;
   endfunction

   function automatic logic [7:0] random_alnum();
      if ($urandom_range(0, 3) == 0) return 8'(8'h30 + $urandom_range(0, 9));
      return random_letter();
   endfunction

   function automatic logic [7:0] random_separator();
      case ($urandom_range(0, 6))
         0: return B_LPAREN;
         1: return B_RPAREN;
         2: return B_COMMA;
         3: return B_DOT;
         4: return B_NL;
         5: return B_TAB;
         default: return B_SPACE;
      endcase
   endfunction

   function automatic void push_comment_word(input int n);
      for (int k = 0; k < n; k++) push_byte(kwlt_pkg::COMMENT_TEXT[8 * (6 - k) +: 8]);
   endfunction

   // one piece of source text, mostly well formed
   function automatic void add_fragment();
      int         pick;
      int         n;
      int         j;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 13) begin
         push_end();
      end else if (pick < 38) begin
         // keyword, now and then one byte short or one byte long
         j = $urandom_range(0, kwlt_pkg::NUM_KEYS - 1);
         n = int'(kwlt_pkg::KEY_LEN[j]);
         if ($urandom_range(0, 4) == 0) n = n - 1;
         for (int k = 0; k < n; k++)
            push_byte(kwlt_pkg::KEY_TEXT[j][8 * (int'(kwlt_pkg::KEY_LEN[j]) - 1 - k) +: 8]);
         if ($urandom_range(0, 4) == 0) push_byte(random_alnum());
      end else if (pick < 48) begin
         n = $urandom_range(1, 12);
         push_byte(random_letter());
         for (int k = 1; k < n; k++) push_byte(random_alnum());
      end else if (pick < 56) begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++) push_byte(8'(8'h30 + $urandom_range(0, 9)));
      end else if (pick < 64) begin
         push_byte(B_QUOTE);
         n = $urandom_range(0, 6);
         for (int k = 0; k < n; k++) begin
            c = 8'($urandom_range(8'h20, 8'h7e));
            if (c == B_QUOTE || $urandom_range(0, 9) == 0) c = B_NL;
            push_byte(c);
         end
         if ($urandom_range(0, 7) != 0) push_byte(B_QUOTE);
      end else if (pick < 72) begin
         case ($urandom_range(0, 3))
            0: push_byte(B_LPAREN);
            1: push_byte(B_RPAREN);
            2: push_byte(B_COMMA);
            default: push_byte(B_DOT);
         endcase
      end else if (pick < 82) begin
         case ($urandom_range(0, 4))
            0: push_byte(B_SPACE);
            1: push_byte(B_TAB);
            2: push_byte(B_CR);
            default: push_byte(B_NL);
         endcase
      end else if (pick < 90) begin
         push_comment_word(7);
         case ($urandom_range(0, 5))
            0: push_byte(B_NL);
            1: push_end();
            default: begin
               push_byte(random_separator() == B_NL ? B_NL : B_SPACE);
               n = $urandom_range(0, 8);
               for (int k = 0; k < n; k++) begin
                  c = 8'($urandom_range(0, 255));
                  push_byte(c == B_NL ? B_QUOTE : c);
               end
               push_byte(B_NL);
            end
         endcase
      end else if (pick < 94) begin
         // near misses of the comment word
         if ($urandom_range(0, 1)) begin
            push_comment_word(7);
            push_byte(random_alnum());
         end else begin
            push_comment_word(6);
         end
      end else begin
         c = 8'($urandom_range(0, 255));
         while (byte_is_lexical(c)) c = 8'($urandom_range(0, 255));
         push_byte(c);
      end
      if (pick >= 13 && pick < 64 && $urandom_range(0, 1)) push_byte(random_separator());
   endfunction

   task automatic add_random(input int n);
      int target;
      target = bytes_queued + n;
      while (bytes_queued < target) add_fragment();
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || beats_offered != beats_taken ||
             expected_tokens.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_first_line(input logic [23:0] value);
      drain();
      @(negedge clock);
      csr_bus.first_line <= value;
      csr_bus.valid      <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      first_line_q = value;
      if (pos_q == '0) line_q = first_line_q;
      csr_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic start_phase(input idle_mode_type mode);
      @(posedge clock);
      idle_mode = mode;
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.ch           = 8'h00;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.first_line   = '0;
      first_line_q         = 24'd1;
      clear_scan();
      repeat (11) @(negedge clock);
      reset = 1'b0;

      write_first_line('0);
      start_phase(IDLE_NONE);
      push_str("7(");
      push_str("x\n");
      push_byte(8'h00);
      push_byte(8'hff);
      push_str("\"a\"");
      push_str(",.");
      push_end();
      push_str("comment z");
      push_end();
      push_str("\"q");
      push_end();

      write_first_line(24'($urandom_range(2, 24'hFFFFF0)));
      start_phase(IDLE_NONE);
      add_random(95);
      // leave a byte taken so the next write does not reload the line count
      push_str("ab");

      write_first_line(24'hFFFFFD);
      start_phase(IDLE_SENDER);
      add_random(95);

      write_first_line(FIELD_MAX);
      start_phase(IDLE_RECEIVER);
      add_random(95);

      write_first_line(24'($urandom_range(0, 24'hFFFFFF)));
      start_phase(IDLE_BOTH);
      add_random(95);

      // output held off while the source keeps offering bytes
      write_first_line(24'd1);
      start_phase(IDLE_NONE);
      hold_wanted = 1'b1;
      add_random(95);

      write_first_line(24'hFFFFFE);
      start_phase(IDLE_BOTH);
      add_random(50);
      drain();
      add_random(50);
      push_end();

      drain();
      $display("%0d source beats (%0d end markers) over %0d first_line settings",
               bytes_queued, ends_queued, csr_writes);
      $display("%0d token beats checked, %0d mismatches", tokens_checked, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
